// ===== hw/rtl/mwmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmf_pkg
// Shared types and constants for the masked window median filter.
// ----------------------------------------------------------------------------
package mwmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 3;
   localparam int RING_SIZE  = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(RING_SIZE);
   localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
   localparam int WIN_MAX    = WIN_SIDE * WIN_SIDE;
   localparam int QUEUE_DEPTH = 4;

   // Register byte offsets
   localparam logic [3:0] REG_WIDTH  = 4'd0;
   localparam logic [3:0] REG_HEIGHT = 4'd4;
   localparam logic [3:0] REG_RADIUS = 4'd8;

   // Item kinds
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Effective frame geometry
   typedef struct packed {
      logic [10:0] w;
      logic [10:0] h;
      logic [1:0]  r;
   } geom_type;

   // One output position handed from front to back
   typedef struct packed {
      logic [ADDR_W-1:0] ptr;
      logic [9:0]        row;
      logic [9:0]        col;
      logic              last;
   } job_type;

   // Line store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [8:0]        data;
   } wr_type;

endpackage

// ===== hw/rtl/mwmf_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmf_csr
// Configuration registers with clamped effective geometry.
// ----------------------------------------------------------------------------
module mwmf_csr import mwmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output geom_type    geom
);

   logic [10:0] width_ff;
   logic [10:0] height_ff;
   logic [1:0]  radius_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Register writes, word decode
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
         radius_ff <= 2'd1;
      end else if (wr_en) begin
         unique case ({paddr[3:2], 2'b00})
            REG_WIDTH:  width_ff  <= pwdata[10:0];
            REG_HEIGHT: height_ff <= pwdata[10:0];
            REG_RADIUS: radius_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case ({paddr[3:2], 2'b00})
         REG_WIDTH:  prdata = {21'd0, width_ff};
         REG_HEIGHT: prdata = {21'd0, height_ff};
         REG_RADIUS: prdata = {30'd0, radius_ff};
         default:    prdata = 32'd0;
      endcase
   end

   // Clamp to the supported range
   always_comb begin
      if (width_ff == 11'd0) geom.w = 11'd1;
      else if (width_ff > 11'(MAX_WIDTH)) geom.w = 11'(MAX_WIDTH);
      else geom.w = width_ff;
      if (height_ff == 11'd0) geom.h = 11'd1;
      else if (height_ff > 11'(MAX_HEIGHT)) geom.h = 11'(MAX_HEIGHT);
      else geom.h = height_ff;
      if (radius_ff == 2'd0) geom.r = 2'd1;
      else geom.r = radius_ff;
   end

endmodule

// ===== hw/rtl/mwmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmf_front
// Accepts items, writes the line store and decides which output is due.
// ----------------------------------------------------------------------------
module mwmf_front import mwmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  geom_type   geom,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_pixel,
   input  logic       req_mask_on,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job,
   output wr_type     wr
);

   logic [9:0]        in_row_ff, in_row_in, in_col_ff, in_col_in;
   logic [19:0]       in_idx_ff, in_idx_in;
   logic [9:0]        out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [ADDR_W-1:0] out_ptr_ff, out_ptr_in;
   logic [12:0]       ahead_ff, ahead_in;
   logic              accept, pix;
   logic [10:0]       icol_p1, irow_p1, ocol_p1, orow_p1;
   logic [12:0]       ahead_n, thr;

   assign req_stall = q_full;
   assign accept    = req_valid & ~req_stall;
   assign pix       = accept & (req_func == FUNC_PIXEL);

   assign wr.en   = pix;
   assign wr.addr = out_ptr_ff + ADDR_W'(ahead_ff);
   assign wr.data = {req_mask_on, req_pixel};

   assign icol_p1 = {1'b0, in_col_ff} + 11'd1;
   assign irow_p1 = {1'b0, in_row_ff} + 11'd1;
   assign ocol_p1 = {1'b0, out_col_ff} + 11'd1;
   assign orow_p1 = {1'b0, out_row_ff} + 11'd1;
   assign thr     = 13'(geom.r) * 13'(geom.w) + 13'(geom.r);

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_idx_in  = in_idx_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      out_ptr_in = out_ptr_ff;
      ahead_n    = ahead_ff + 13'(pix);
      ahead_in   = ahead_n;
      q_push     = 1'b0;

      // Advance the input position
      if (pix) begin
         if (icol_p1 == geom.w) begin
            in_col_in = 10'd0;
            if (irow_p1 == geom.h) begin
               in_row_in = 10'd0;
               in_idx_in = 20'd0;
            end else begin
               in_row_in = irow_p1[9:0];
               in_idx_in = in_idx_ff + 20'd1;
            end
         end else begin
            in_col_in = icol_p1[9:0];
            in_idx_in = in_idx_ff + 20'd1;
         end
      end

      // Output due once its window is complete or the frame has ended
      if (accept && ahead_n != 13'd0 &&
          (ahead_n > thr || 20'(ahead_n) > in_idx_in)) begin
         q_push     = 1'b1;
         ahead_in   = ahead_n - 13'd1;
         out_ptr_in = out_ptr_ff + ADDR_W'(1);
         if (ocol_p1 == geom.w) begin
            out_col_in = 10'd0;
            out_row_in = (orow_p1 == geom.h) ? 10'd0 : orow_p1[9:0];
         end else begin
            out_col_in = ocol_p1[9:0];
         end
      end
   end

   assign q_job.ptr  = out_ptr_ff;
   assign q_job.row  = out_row_ff;
   assign q_job.col  = out_col_ff;
   assign q_job.last = (orow_p1 == geom.h) && (ocol_p1 == geom.w);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_idx_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         out_ptr_ff <= '0;
         ahead_ff   <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_idx_ff  <= in_idx_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         out_ptr_ff <= out_ptr_in;
         ahead_ff   <= ahead_in;
      end
   end

endmodule

// ===== hw/rtl/mwmf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmf_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mwmf_queue import mwmf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [PW:0]     cnt_ff;

   assign head  = slot_ff[rp_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PW+1)'(QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + PW'(1);
         if (pop)  rp_ff <= rp_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

endmodule

// ===== hw/rtl/mwmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwmf_back
// Holds the line store; gathers each window and selects its median.
// ----------------------------------------------------------------------------
module mwmf_back import mwmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  geom_type    geom,
   input  wr_type      wr,
   input  job_type     q_head,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_value,
   output logic        rsp_written,
   output logic [9:0]  rsp_row,
   output logic [9:0]  rsp_col,
   output logic        rsp_last
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CENT  = 8'b0000_0010,
      S_CWAIT = 8'b0000_0100,
      S_GATH  = 8'b0000_1000,
      S_GWAIT = 8'b0001_0000,
      S_CMP   = 8'b0010_0000,
      S_CNT   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [8:0]        mem [RING_SIZE];
   logic [8:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   job_type           job_ff;

   logic [ADDR_W-1:0] gaddr_ff, row_base_ff;
   logic [1:0]        col_up_ff;
   logic [2:0]        rows_ff, cols_ff, ri_ff, ci_ff;
   logic              cap_ff;
   logic [5:0]        n_ff;
   logic [7:0]        lane_ff [WIN_MAX];
   logic [WIN_MAX-1:0] lane_vld_ff;
   logic [WIN_MAX-1:0] le_ff;
   logic [2:0]        bit_ff;
   logic [7:0]        cand_ff;
   logic [7:0]        value_ff;
   logic              written_ff;
   logic              rsp_valid_ff;

   // Window extent around the job position
   logic [1:0]        row_up, row_dn, col_up, col_dn;
   logic [10:0]       row_rem, col_rem;
   logic [ADDR_W-1:0] base0;
   logic [7:0]        low_mask;
   logic [7:0]        thr_val;
   logic [5:0]        le_cnt;

   function automatic logic [5:0] pop_count(input logic [WIN_MAX-1:0] v);
      logic [5:0] s;
      s = '0;
      for (int i = 0; i < WIN_MAX; i++) s = s + 6'(v[i]);
      return s;
   endfunction

   assign row_rem = geom.h - 11'd1 - {1'b0, job_ff.row};
   assign col_rem = geom.w - 11'd1 - {1'b0, job_ff.col};
   assign row_up  = (job_ff.row < 10'(geom.r)) ? job_ff.row[1:0] : geom.r;
   assign col_up  = (job_ff.col < 10'(geom.r)) ? job_ff.col[1:0] : geom.r;
   assign row_dn  = (row_rem < 11'(geom.r)) ? row_rem[1:0] : geom.r;
   assign col_dn  = (col_rem < 11'(geom.r)) ? col_rem[1:0] : geom.r;
   assign base0   = job_ff.ptr - ADDR_W'(row_up) * ADDR_W'(geom.w);

   assign low_mask = 8'((9'd1 << bit_ff) - 9'd1);
   assign thr_val  = cand_ff | low_mask;
   assign le_cnt   = pop_count(le_ff);

   // Line store
   assign rd_addr = (state_ff == S_CENT) ? job_ff.ptr : gaddr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      rd_data_ff <= mem[rd_addr];
   end

   // Control sequencer
   assign q_pop = (state_ff == S_IDLE) && !q_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (!q_empty) state_in = S_CENT;
         S_CENT:  state_in = S_CWAIT;
         S_CWAIT: state_in = rd_data_ff[8] ? S_GATH : S_OUT;
         S_GATH:  if (ci_ff == cols_ff - 3'd1 && ri_ff == rows_ff - 3'd1)
                     state_in = S_GWAIT;
         S_GWAIT: state_in = S_CMP;
         S_CMP:   state_in = S_CNT;
         S_CNT:   state_in = (bit_ff == 3'd0) ? S_OUT : S_CMP;
         S_OUT:   if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= (state_ff == S_GATH);
         if (state_in == S_OUT && state_ff != S_OUT) rsp_valid_ff <= 1'b1;
         else if (state_ff == S_OUT && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_head;

      // Window setup
      if (state_ff == S_CENT) begin
         rows_ff     <= 3'(row_up) + 3'(row_dn) + 3'd1;
         cols_ff     <= 3'(col_up) + 3'(col_dn) + 3'd1;
         col_up_ff   <= col_up;
         row_base_ff <= base0;
         gaddr_ff    <= base0 - ADDR_W'(col_up);
         ri_ff       <= '0;
         ci_ff       <= '0;
         n_ff        <= '0;
         lane_vld_ff <= '0;
      end

      // Walk the window one entry per cycle
      if (state_ff == S_GATH) begin
         if (ci_ff == cols_ff - 3'd1) begin
            ci_ff       <= '0;
            ri_ff       <= ri_ff + 3'd1;
            row_base_ff <= row_base_ff + ADDR_W'(geom.w);
            gaddr_ff    <= row_base_ff + ADDR_W'(geom.w) - ADDR_W'(col_up_ff);
         end else begin
            ci_ff    <= ci_ff + 3'd1;
            gaddr_ff <= gaddr_ff + ADDR_W'(1);
         end
      end

      // Shift read data into the lanes
      if (cap_ff) begin
         lane_ff[0]     <= rd_data_ff[7:0];
         lane_vld_ff[0] <= 1'b1;
         for (int i = 1; i < WIN_MAX; i++) begin
            lane_ff[i]     <= lane_ff[i-1];
            lane_vld_ff[i] <= lane_vld_ff[i-1];
         end
         n_ff <= n_ff + 6'd1;
      end

      if (state_ff == S_GWAIT) begin
         bit_ff  <= 3'd7;
         cand_ff <= 8'd0;
      end

      // Bitwise rank search: compare all lanes, then count
      if (state_ff == S_CMP) begin
         for (int i = 0; i < WIN_MAX; i++)
            le_ff[i] <= lane_vld_ff[i] && (lane_ff[i] <= thr_val);
      end

      if (state_ff == S_CNT) begin
         if (le_cnt <= (n_ff >> 1)) cand_ff[bit_ff] <= 1'b1;
         bit_ff <= bit_ff - 3'd1;
      end

      // Result register
      if (state_ff == S_CWAIT && !rd_data_ff[8]) begin
         value_ff   <= 8'd0;
         written_ff <= 1'b0;
      end else if (state_ff == S_CNT && bit_ff == 3'd0) begin
         value_ff   <= cand_ff | ((le_cnt <= (n_ff >> 1)) ? 8'd1 : 8'd0);
         written_ff <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = value_ff;
   assign rsp_written = written_ff;
   assign rsp_row     = job_ff.row;
   assign rsp_col     = job_ff.col;
   assign rsp_last    = job_ff.last;

endmodule

// ===== hw/rtl/masked_window_median_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_window_median_filter
// Masked median over a square window clipped at the frame borders.
//
//   port group   direction  handshake
//   req_*        in         req_valid / req_stall
//   rsp_*        out        rsp_valid / rsp_stall
//   p*           in/out     APB write on psel&penable&pwrite, pready tied high
//
// The front takes one item per cycle while the job queue has room.
// An output with a clear mask bit skips the window walk in the back part;
// one with a set mask bit reads its window through the single line-store
// read port and then runs the 8-step bitwise rank search.
// Reset is synchronous; the line store is not cleared.
// rsp_stall holds the result register and, once the queue fills, req_stall.
// ----------------------------------------------------------------------------
module masked_window_median_filter import mwmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_pixel,
   input  logic        req_mask_on,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_value,
   output logic        rsp_written,
   output logic [9:0]  rsp_row,
   output logic [9:0]  rsp_col,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   geom_type geom;
   wr_type   wr;
   job_type  push_job, head;
   logic     push, pop, empty, full;

   mwmf_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .geom
   );

   mwmf_front u_front (
      .clock, .reset, .geom, .req_valid, .req_stall, .req_func, .req_pixel,
      .req_mask_on, .q_full(full), .q_push(push), .q_job(push_job), .wr
   );

   mwmf_queue u_queue (
      .clock, .reset, .push, .push_job, .pop, .head, .empty, .full
   );

   mwmf_back u_back (
      .clock, .reset, .geom, .wr, .q_head(head), .q_empty(empty), .q_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_written, .rsp_row, .rsp_col,
      .rsp_last
   );

endmodule

// ===== tb/sv/tb_masked_window_median_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_window_median_filter
// Self-checking bench for the masked window median filter. Whole frames of
// random pixels and mask bits go in over several frame geometries and window
// radii, including out-of-range register values. A behavioral median
// predictor builds the expected output pixels, and a scoreboard compares
// them in order with what the block returns. Random idle cycles on both
// sides, one long output hold-off and one input pause exercise the
// flow control.
// ----------------------------------------------------------------------------
module tb_masked_window_median_filter import mwmf_pkg::*; ();

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEM_TARGET = 1750;
   localparam int SETTLE      = 100;

   // One expected output pixel
   typedef struct {
      logic [7:0] value;
      logic       written;
      logic [9:0] row;
      logic [9:0] col;
      logic       last;
   } out_pixel_type;

   // Median predictor plus ordered store of expected output pixels
   class median_scoreboard_type;
      logic [8:0]  ring [RING_SIZE];
      int          in_row, in_col, out_row, out_col, ahead, out_ptr;
      logic [10:0] width_reg, height_reg;
      logic [1:0]  radius_reg;
      out_pixel_type expected_q [$];
      int          errors;

      function new();
         width_reg  = 11'd640;
         height_reg = 11'd480;
         radius_reg = 2'd1;
      endfunction

      function int eff_w();
         return (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      endfunction

      function int eff_h();
         return (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      endfunction

      function int eff_r();
         return (radius_reg == 0) ? 1 : radius_reg;
      endfunction

      // clipped window, value at rank n/2 found from a histogram
      function logic [7:0] median_at(int w, int h, int rad);
         int hist [256];
         int lo_r, hi_r, lo_c, hi_c, n, acc, off, a;
         for (int v = 0; v < 256; v++) hist[v] = 0;
         lo_r = (out_row >= rad) ? out_row - rad : 0;
         hi_r = (out_row + rad < h) ? out_row + rad : h - 1;
         lo_c = (out_col >= rad) ? out_col - rad : 0;
         hi_c = (out_col + rad < w) ? out_col + rad : w - 1;
         n = 0;
         for (int r = lo_r; r <= hi_r; r++) begin
            for (int c = lo_c; c <= hi_c; c++) begin
               off = (r - out_row) * w + (c - out_col);
               a = (out_ptr + off + RING_SIZE) % RING_SIZE;
               hist[ring[a][7:0]]++;
               n++;
            end
         end
         acc = 0;
         for (int v = 0; v < 256; v++) begin
            acc += hist[v];
            if (acc > n / 2) return v[7:0];
         end
         return 8'd0;
      endfunction

      // accepted input item: update state, maybe queue one output pixel
      function void note_item(logic func, logic [7:0] pix, logic mask);
         int w, h, rad, in_index;
         out_pixel_type o;
         w = eff_w();
         h = eff_h();
         rad = eff_r();
         if (in_col >= w) begin in_col = 0; in_row++; end
         if (in_row >= h) in_row = 0;
         if (out_col >= w) begin out_col = 0; out_row++; end
         if (out_row >= h) out_row = 0;
         if (func == FUNC_PIXEL) begin
            ring[(out_ptr + ahead) % RING_SIZE] = {mask, pix};
            ahead++;
            in_col++;
            if (in_col >= w) begin in_col = 0; in_row++; end
            if (in_row >= h) in_row = 0;
         end
         in_index = in_row * w + in_col;
         if (ahead == 0 || !(ahead > rad * w + rad || ahead > in_index)) return;
         o.written = ring[out_ptr % RING_SIZE][8];
         o.value   = o.written ? median_at(w, h, rad) : 8'd0;
         o.row     = out_row[9:0];
         o.col     = out_col[9:0];
         o.last    = (out_row == h - 1 && out_col == w - 1);
         expected_q.insert(expected_q.size(), o);
         ahead--;
         out_ptr = (out_ptr + 1) % RING_SIZE;
         out_col++;
         if (out_col >= w) begin out_col = 0; out_row++; end
         if (out_row >= h) out_row = 0;
      endfunction

      function void check_result(out_pixel_type got);
         out_pixel_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected output pixel row %0d col %0d", got.row, got.col);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, got.value);
            errors++;
         end
         if (got.written !== e.written) begin
            $error("written: expected %0d, got %0d", e.written, got.written);
            errors++;
         end
         if (got.row !== e.row) begin
            $error("row: expected %0d, got %0d", e.row, got.row);
            errors++;
         end
         if (got.col !== e.col) begin
            $error("col: expected %0d, got %0d", e.col, got.col);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_PIXEL;
   logic [7:0]  req_pixel = 8'd0;
   logic        req_mask_on = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_value;
   logic        rsp_written;
   logic [9:0]  rsp_row;
   logic [9:0]  rsp_col;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   median_scoreboard_type sb = new();
   int  cycles = 0;
   int  items_sent = 0;
   bit  long_hold_req = 1'b0;
   bit  quiet = 1'b0;

   masked_window_median_filter DUT (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls plus one long hold-off on request
   int stall_left = 0;
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left = 400;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall = (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      out_pixel_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.value   = rsp_value;
         got.written = rsp_written;
         got.row     = rsp_row;
         got.col     = rsp_col;
         got.last    = rsp_last;
         sb.check_result(got);
      end
   end

   task automatic send_item(logic func, logic [7:0] pix, logic mask);
      int n;
      n = pick_gap();
      repeat (n) @(negedge clock) req_valid = 1'b0;
      @(negedge clock);
      req_valid   = 1'b1;
      req_func    = func;
      req_pixel   = pix;
      req_mask_on = mask;
      do @(posedge clock); while (req_stall);
      sb.note_item(func, pix, mask);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock) req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [3:0] addr, logic [31:0] data,
                             output logic [31:0] rd);
      @(negedge clock);
      psel = 1'b1; pwrite = wr; paddr = addr; pwdata = data; penable = 1'b0;
      @(negedge clock) penable = 1'b1;
      @(posedge clock) rd = prdata;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // write and read back all three registers while idle
   task automatic set_geometry(int w, int h, int r);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, REG_WIDTH, w, rd);
      csr_access(1'b1, REG_HEIGHT, h, rd);
      csr_access(1'b1, REG_RADIUS, r, rd);
      sb.width_reg  = w[10:0];
      sb.height_reg = h[10:0];
      sb.radius_reg = r[1:0];
      csr_access(1'b0, REG_WIDTH, 0, rd);
      if (rd[10:0] !== w[10:0]) $error("width readback: expected %0d, got %0d", w, rd);
      csr_access(1'b0, REG_HEIGHT, 0, rd);
      if (rd[10:0] !== h[10:0]) $error("height readback: expected %0d, got %0d", h, rd);
      csr_access(1'b0, REG_RADIUS, 0, rd);
      if (rd[1:0] !== r[1:0]) $error("radius readback: expected %0d, got %0d", r, rd);
   endtask

   // one frame; mask_pct sets how many positions are masked in,
   // extremes forces 0/255 pixels, flush sends drain beats afterward
   task automatic send_frame(int mask_pct, bit extremes, bit flush);
      int npix;
      logic [7:0] pix;
      npix = sb.eff_w() * sb.eff_h();
      for (int i = 0; i < npix; i++) begin
         if ($urandom_range(0, 99) < 3)
            send_item(FUNC_DRAIN, 8'($urandom), 1'($urandom));
         pix = extremes ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00) : 8'($urandom);
         send_item(FUNC_PIXEL, pix, $urandom_range(0, 99) < mask_pct);
      end
      if (flush) begin
         while (sb.ahead > 0) send_item(FUNC_DRAIN, 8'($urandom), 1'($urandom));
         // drain beat with nothing pending
         if ($urandom_range(0, 3) == 0) send_item(FUNC_DRAIN, 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: small frames, extreme pixels, odd register values
      set_geometry(4, 3, 1);
      send_frame(100, 1'b1, 1'b1);
      send_frame(50, 1'b0, 1'b1);
      set_geometry(0, 0, 0);
      send_frame(100, 1'b0, 1'b1);
      set_geometry(1, 5, 3);
      send_frame(100, 1'b1, 1'b1);
      set_geometry(5, 1, 2);
      send_frame(100, 1'b0, 1'b1);

      // widest frame, width clamped, mostly masked out to keep it quick
      set_geometry(2047, 1, 3);
      send_frame(3, 1'b0, 1'b1);

      // random geometries, several frames each, some chained without drain
      phase = 0;
      while (items_sent < ITEM_TARGET || phase < 5) begin
         set_geometry($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 3));
         quiet = ($urandom_range(0, 3) == 0);
         if (phase == 2) long_hold_req = 1'b1;
         repeat ($urandom_range(1, 3)) begin
            send_frame($urandom_range(40, 100), 1'b0, $urandom_range(0, 9) < 7);
            if (phase == 4) begin
               @(negedge clock) req_valid = 1'b0;
               while (sb.expected_q.size() != 0) @(posedge clock);
            end
         end
         send_frame($urandom_range(40, 100), 1'b0, 1'b1);
         phase++;
      end
      quiet = 1'b0;

      @(negedge clock) req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== masked_window_median_filter.f =====
hw/rtl/mwmf_pkg.sv
hw/rtl/mwmf_csr.sv
hw/rtl/mwmf_front.sv
hw/rtl/mwmf_queue.sv
hw/rtl/mwmf_back.sv
hw/rtl/masked_window_median_filter.sv
tb/sv/tb_masked_window_median_filter.sv
